/* sv/hierarchical_page_table_vm_macros.svh */
// Assertion macros used by the checker file of the page-table block.
`ifndef HIERARCHICAL_PAGE_TABLE_VM_MACROS_SVH
`define HIERARCHICAL_PAGE_TABLE_VM_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define HPTVM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("hptvm: assertion failed");

// Next-cycle implication, quiet during reset.
`define HPTVM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("hptvm: assertion failed");

// Next-cycle implication that also checks across reset.
`define HPTVM_ASSERT_RST(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("hptvm: assertion failed");

`endif

/* sv/hptvm_pkg.sv */
// Shared types and default configuration of the page-table walker.
`timescale 1ns / 1ps
`default_nettype none
package hptvm_pkg;

    localparam int OFFSET_BITS_DEF = 4;
    localparam int LEVELS_DEF      = 3;
    localparam int VADDR_BITS_DEF  = 16;
    localparam int FRAME_COUNT_DEF = 64;
    localparam int WORD_BITS_DEF   = 32;

    typedef struct packed {
        logic               req_type;
        logic [31:0]        virtual_address;
        logic signed [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic               success;
    } t_result;

endpackage
`default_nettype wire

/* sv/hptvm_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hptvm_ram #(
    parameter int     WIDTH = 32,
    parameter int     AW    = 10,
    parameter longint DEPTH = longint'(1) << AW
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/hptvm_ctrl.sv */
// Sequencer: table walk, fault handling tree scans, swap traffic and clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module hptvm_ctrl #(
    parameter int OFFSET_BITS = hptvm_pkg::OFFSET_BITS_DEF,
    parameter int LEVELS      = hptvm_pkg::LEVELS_DEF,
    parameter int VADDR_BITS  = hptvm_pkg::VADDR_BITS_DEF,
    parameter int FRAME_COUNT = hptvm_pkg::FRAME_COUNT_DEF,
    parameter int WORD_BITS   = hptvm_pkg::WORD_BITS_DEF,
    localparam int FB = $clog2(FRAME_COUNT),
    localparam int MA = FB + OFFSET_BITS,
    localparam int NP = LEVELS * OFFSET_BITS,
    localparam int SA = NP + OFFSET_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire hptvm_pkg::t_req      i_req,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output hptvm_pkg::t_result        o_res,
    output logic                      o_pm_we,
    output logic [MA-1:0]             o_pm_waddr,
    output logic [WORD_BITS-1:0]      o_pm_wdata,
    output logic                      o_pm_re,
    output logic [MA-1:0]             o_pm_raddr,
    input  wire logic [WORD_BITS-1:0] i_pm_rdata,
    output logic                      o_sw_we,
    output logic [SA-1:0]             o_sw_waddr,
    output logic [WORD_BITS-1:0]      o_sw_wdata,
    output logic                      o_sw_re,
    output logic [SA-1:0]             o_sw_raddr,
    input  wire logic [WORD_BITS-1:0] i_sw_rdata,
    output logic                      o_sv_we,
    output logic [NP-1:0]             o_sv_waddr,
    output logic                      o_sv_wdata,
    output logic                      o_sv_re,
    output logic [NP-1:0]             o_sv_raddr,
    input  wire logic                 i_sv_rdata
);

    localparam int DB        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CLR       = (MA > NP) ? MA : NP;
    localparam int MEM_WORDS = FRAME_COUNT * (1 << OFFSET_BITS);

    typedef enum logic [20:0] {
        S_INIT    = 21'h000001,
        S_IDLE    = 21'h000002,
        S_WALK_RD = 21'h000004,
        S_WALK_EV = 21'h000008,
        S_SCAN_RD = 21'h000010,
        S_SCAN_EV = 21'h000020,
        S_EMP_RD  = 21'h000040,
        S_EMP_EV  = 21'h000080,
        S_ADV     = 21'h000100,
        S_ZERO    = 21'h000200,
        S_SAVE_RD = 21'h000400,
        S_SAVE_WR = 21'h000800,
        S_UNLINK  = 21'h001000,
        S_SWV_RD  = 21'h002000,
        S_SWV_EV  = 21'h004000,
        S_REST_RD = 21'h008000,
        S_REST_WR = 21'h010000,
        S_LINK    = 21'h020000,
        S_ACC     = 21'h040000,
        S_ACC_EV  = 21'h080000,
        S_FIN     = 21'h100000
    } t_state;

    typedef enum logic [1:0] {
        M_TAKE = 2'd0,
        M_MAX  = 2'd1,
        M_VICT = 2'd2
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [CLR-1:0] r_clr, n_clr;
    logic r_is_wr, n_is_wr;
    logic [31:0] r_va, n_va;
    logic signed [31:0] r_wd, n_wd;
    logic [DB-1:0] r_lv, n_lv;
    logic [FB-1:0] r_cur, n_cur;
    logic [FB-1:0] r_path [LEVELS];
    logic [FB-1:0] n_path [LEVELS];
    logic [DB-1:0] r_dep, n_dep;
    logic [FB-1:0] r_sf [LEVELS];
    logic [FB-1:0] n_sf [LEVELS];
    logic [OFFSET_BITS-1:0] r_si [LEVELS];
    logic [OFFSET_BITS-1:0] n_si [LEVELS];
    logic [FB-1:0] r_e, n_e;
    logic [OFFSET_BITS-1:0] r_j, n_j;
    logic [FB-1:0] r_max, n_max;
    logic [FB-1:0] r_f, n_f;
    logic r_evfound, n_evfound;
    logic [NP-1:0] r_evdist, n_evdist;
    logic [NP-1:0] r_evpage, n_evpage;
    logic [FB-1:0] r_evf, n_evf;
    logic [MA-1:0] r_evslot, n_evslot;
    hptvm_pkg::t_result r_res, n_res;

    logic [OFFSET_BITS-1:0] cur_idx;
    logic [NP-1:0] page;
    logic [FB-1:0] entry_f;
    logic entry_nz;
    logic lv_last;
    logic dep_leaf;
    logic [DB-1:0] dep_up;
    logic [MA-1:0] scan_addr;
    logic [NP-1:0] vp;
    logic [NP-1:0] diff, negd, cyc_dist;
    logic [FB:0] f1;
    logic e_on_path;

    function automatic logic [OFFSET_BITS-1:0] lvl_idx(input logic [31:0] va,
                                                      input logic [DB-1:0] lv);
        logic [31:0] t;
        t = va >> (OFFSET_BITS * (LEVELS - int'(lv)));
        return t[OFFSET_BITS-1:0];
    endfunction

    assign cur_idx   = lvl_idx(r_va, r_lv);
    assign page      = NP'(r_va >> OFFSET_BITS);
    assign entry_f   = FB'(i_pm_rdata);
    assign entry_nz  = |i_pm_rdata;
    assign lv_last   = (r_lv == DB'(LEVELS - 1));
    assign dep_leaf  = (r_dep == DB'(LEVELS - 1));
    assign dep_up    = r_dep + 1'b1;
    assign scan_addr = {r_sf[r_dep], r_si[r_dep]};
    assign f1        = {1'b0, r_max} + 1'b1;

    // Page number of the leaf entry under the scan pointer.
    always_comb begin
        vp = '0;
        for (int k = 0; k < LEVELS; k++) begin
            vp = (vp << OFFSET_BITS) | NP'(r_si[k]);
        end
    end

    // Cyclic distance to the requested page.
    assign diff     = page - vp;
    assign negd     = NP'(0) - diff;
    assign cyc_dist = (diff < negd) ? diff : negd;

    always_comb begin
        e_on_path = 1'b0;
        for (int k = 0; k < LEVELS; k++) begin
            if (k < int'(r_lv) && r_path[k] == r_e) begin
                e_on_path = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_clr     = r_clr;
        n_is_wr   = r_is_wr;
        n_va      = r_va;
        n_wd      = r_wd;
        n_lv      = r_lv;
        n_cur     = r_cur;
        n_path    = r_path;
        n_dep     = r_dep;
        n_sf      = r_sf;
        n_si      = r_si;
        n_e       = r_e;
        n_j       = r_j;
        n_max     = r_max;
        n_f       = r_f;
        n_evfound = r_evfound;
        n_evdist  = r_evdist;
        n_evpage  = r_evpage;
        n_evf     = r_evf;
        n_evslot  = r_evslot;
        n_res     = r_res;
        o_pm_we    = 1'b0;
        o_pm_waddr = '0;
        o_pm_wdata = '0;
        o_pm_re    = 1'b0;
        o_pm_raddr = '0;
        o_sw_we    = 1'b0;
        o_sw_waddr = '0;
        o_sw_wdata = '0;
        o_sw_re    = 1'b0;
        o_sw_raddr = '0;
        o_sv_we    = 1'b0;
        o_sv_waddr = '0;
        o_sv_wdata = 1'b0;
        o_sv_re    = 1'b0;
        o_sv_raddr = '0;

        case (r_state)
            S_INIT: begin
                if ((r_clr >> MA) == '0 && int'(MA'(r_clr)) < MEM_WORDS) begin
                    o_pm_we    = 1'b1;
                    o_pm_waddr = MA'(r_clr);
                end
                if ((r_clr >> NP) == '0) begin
                    o_sv_we    = 1'b1;
                    o_sv_waddr = NP'(r_clr);
                end
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_is_wr = i_req.req_type;
                    n_va    = i_req.virtual_address;
                    n_wd    = i_req.write_data;
                    n_lv    = '0;
                    n_cur   = '0;
                    if ((i_req.virtual_address >> VADDR_BITS) != '0) begin
                        n_res   = '0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                o_pm_re    = 1'b1;
                o_pm_raddr = {r_cur, cur_idx};
                n_state    = S_WALK_EV;
            end
            S_WALK_EV: begin
                if (entry_nz) begin
                    n_cur = entry_f;
                    if (lv_last) begin
                        n_state = S_ACC;
                    end else begin
                        n_path[r_lv] = entry_f;
                        n_lv         = r_lv + 1'b1;
                        n_state      = S_WALK_RD;
                    end
                end else begin
                    // Fault: look for an unused empty table first.
                    n_dep   = '0;
                    n_sf[0] = '0;
                    n_si[0] = '0;
                    n_max   = '0;
                    n_state = S_SCAN_RD;
                    n_mode  = (LEVELS > 1) ? M_TAKE : M_MAX;
                end
            end
            S_SCAN_RD: begin
                o_pm_re    = 1'b1;
                o_pm_raddr = scan_addr;
                n_state    = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                n_state = S_ADV;
                if (entry_nz) begin
                    case (r_mode)
                        M_TAKE: begin
                            n_e     = entry_f;
                            n_j     = '0;
                            n_state = S_EMP_RD;
                        end
                        M_MAX: begin
                            if (entry_f > r_max) begin
                                n_max = entry_f;
                            end
                            if (!dep_leaf) begin
                                n_dep         = dep_up;
                                n_sf[dep_up]  = entry_f;
                                n_si[dep_up]  = '0;
                                n_state       = S_SCAN_RD;
                            end
                        end
                        M_VICT: begin
                            if (!dep_leaf) begin
                                n_dep         = dep_up;
                                n_sf[dep_up]  = entry_f;
                                n_si[dep_up]  = '0;
                                n_state       = S_SCAN_RD;
                            end else if (!r_evfound || cyc_dist > r_evdist) begin
                                // Strict compare: the first page found wins ties.
                                n_evfound = 1'b1;
                                n_evdist  = cyc_dist;
                                n_evpage  = vp;
                                n_evf     = entry_f;
                                n_evslot  = scan_addr;
                            end
                        end
                        default: begin
                            n_state = S_ADV;
                        end
                    endcase
                end
            end
            S_EMP_RD: begin
                o_pm_re    = 1'b1;
                o_pm_raddr = {r_e, r_j};
                n_state    = S_EMP_EV;
            end
            S_EMP_EV: begin
                if (entry_nz) begin
                    if (int'(r_dep) + 2 < LEVELS) begin
                        n_dep        = dep_up;
                        n_sf[dep_up] = r_e;
                        n_si[dep_up] = '0;
                        n_state      = S_SCAN_RD;
                    end else begin
                        n_state = S_ADV;
                    end
                end else if (&r_j) begin
                    if (e_on_path) begin
                        n_state = S_ADV;
                    end else begin
                        // Unlink the empty table and reuse it as is.
                        o_pm_we    = 1'b1;
                        o_pm_waddr = scan_addr;
                        n_f        = r_e;
                        n_state    = lv_last ? S_SWV_RD : S_LINK;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_EMP_RD;
                end
            end
            S_ADV: begin
                if (&r_si[r_dep]) begin
                    if (r_dep != '0) begin
                        n_dep = r_dep - 1'b1;
                    end else begin
                        n_dep   = '0;
                        n_sf[0] = '0;
                        n_si[0] = '0;
                        case (r_mode)
                            M_TAKE: begin
                                n_mode  = M_MAX;
                                n_max   = '0;
                                n_state = S_SCAN_RD;
                            end
                            M_MAX: begin
                                if (f1 < (FB + 1)'(FRAME_COUNT)) begin
                                    n_f = FB'(f1);
                                    n_j = '0;
                                    n_state = lv_last ? S_SWV_RD : S_ZERO;
                                end else begin
                                    n_mode    = M_VICT;
                                    n_evfound = 1'b0;
                                    n_evdist  = '0;
                                    n_state   = S_SCAN_RD;
                                end
                            end
                            M_VICT: begin
                                if (r_evfound) begin
                                    n_f     = r_evf;
                                    n_j     = '0;
                                    n_state = S_SAVE_RD;
                                end else begin
                                    n_res   = '0;
                                    n_state = S_FIN;
                                end
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end else begin
                    n_si[r_dep] = r_si[r_dep] + 1'b1;
                    n_state     = S_SCAN_RD;
                end
            end
            S_ZERO: begin
                o_pm_we    = 1'b1;
                o_pm_waddr = {r_f, r_j};
                n_j        = r_j + 1'b1;
                if (&r_j) begin
                    n_state = lv_last ? S_SWV_RD : S_LINK;
                end
            end
            S_SAVE_RD: begin
                o_pm_re    = 1'b1;
                o_pm_raddr = {r_f, r_j};
                n_state    = S_SAVE_WR;
            end
            S_SAVE_WR: begin
                o_sw_we    = 1'b1;
                o_sw_waddr = {r_evpage, r_j};
                o_sw_wdata = i_pm_rdata;
                n_j        = r_j + 1'b1;
                n_state    = (&r_j) ? S_UNLINK : S_SAVE_RD;
            end
            S_UNLINK: begin
                o_sv_we    = 1'b1;
                o_sv_waddr = r_evpage;
                o_sv_wdata = 1'b1;
                o_pm_we    = 1'b1;
                o_pm_waddr = r_evslot;
                n_j        = '0;
                n_state    = S_ZERO;
            end
            S_SWV_RD: begin
                o_sv_re    = 1'b1;
                o_sv_raddr = page;
                n_state    = S_SWV_EV;
            end
            S_SWV_EV: begin
                n_j     = '0;
                n_state = i_sv_rdata ? S_REST_RD : S_LINK;
            end
            S_REST_RD: begin
                o_sw_re    = 1'b1;
                o_sw_raddr = {page, r_j};
                n_state    = S_REST_WR;
            end
            S_REST_WR: begin
                o_pm_we    = 1'b1;
                o_pm_waddr = {r_f, r_j};
                o_pm_wdata = i_sw_rdata;
                n_j        = r_j + 1'b1;
                n_state    = (&r_j) ? S_LINK : S_REST_RD;
            end
            S_LINK: begin
                o_pm_we    = 1'b1;
                o_pm_waddr = {r_cur, cur_idx};
                o_pm_wdata = WORD_BITS'(r_f);
                n_cur      = r_f;
                if (lv_last) begin
                    n_state = S_ACC;
                end else begin
                    n_path[r_lv] = r_f;
                    n_lv         = r_lv + 1'b1;
                    n_state      = S_WALK_RD;
                end
            end
            S_ACC: begin
                if (r_is_wr) begin
                    o_pm_we    = 1'b1;
                    o_pm_waddr = {r_cur, r_va[OFFSET_BITS-1:0]};
                    o_pm_wdata = WORD_BITS'(r_wd);
                    n_res.read_data = '0;
                    n_res.success   = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    o_pm_re    = 1'b1;
                    o_pm_raddr = {r_cur, r_va[OFFSET_BITS-1:0]};
                    n_state    = S_ACC_EV;
                end
            end
            S_ACC_EV: begin
                n_res.read_data = 32'(signed'(i_pm_rdata));
                n_res.success   = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_mode    <= n_mode;
        r_is_wr   <= n_is_wr;
        r_va      <= n_va;
        r_wd      <= n_wd;
        r_lv      <= n_lv;
        r_cur     <= n_cur;
        r_path    <= n_path;
        r_dep     <= n_dep;
        r_sf      <= n_sf;
        r_si      <= n_si;
        r_e       <= n_e;
        r_j       <= n_j;
        r_max     <= n_max;
        r_f       <= n_f;
        r_evfound <= n_evfound;
        r_evdist  <= n_evdist;
        r_evpage  <= n_evpage;
        r_evf     <= n_evf;
        r_evslot  <= n_evslot;
        r_res     <= n_res;
    end

endmodule
`default_nettype wire

/* sv/hierarchical_page_table_vm.sv */
// Top level of the demand-paged page-table walker with swap store.
//
//  Channel   Dir  Transfer when               Payload
//  s_axis    in   tvalid & tready             tdata: virtual_address, write_data
//                                             tuser: req_type
//  m_axis    out  tvalid & tready             tdata: read_data; tuser: success
//
//  A fault runs up to three depth-first scans of the table tree over the
//  physical memory read port, reading the words of each child table
//  probed for emptiness; a fresh table is cleared, eviction saves and
//  clears the frame, and swap-in restores the saved page word by word.
//  After reset a clearing pass over 2**max(frame+offset bits, page bits)
//  addresses zeroes physical memory and the swap flags; requests are held
//  off until it ends.
//  A request is taken while a result still waits on m_axis; the next
//  result waits in the sequencer until the output register drains.
`timescale 1ns / 1ps
`default_nettype none
module hierarchical_page_table_vm #(
    parameter int OFFSET_BITS = hptvm_pkg::OFFSET_BITS_DEF,
    parameter int LEVELS      = hptvm_pkg::LEVELS_DEF,
    parameter int VADDR_BITS  = hptvm_pkg::VADDR_BITS_DEF,
    parameter int FRAME_COUNT = hptvm_pkg::FRAME_COUNT_DEF,
    parameter int WORD_BITS   = hptvm_pkg::WORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [31:0] virtual_address, [63:32] write_data
    input  wire logic [0:0]  i_s_axis_tuser,   // [0] req_type
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] read_data
    output logic [0:0]       o_m_axis_tuser    // [0] success
);

    localparam int FB = $clog2(FRAME_COUNT);
    localparam int MA = FB + OFFSET_BITS;
    localparam int NP = LEVELS * OFFSET_BITS;
    localparam int SA = NP + OFFSET_BITS;

    hptvm_pkg::t_req    req;
    hptvm_pkg::t_result res;
    hptvm_pkg::t_result r_out;
    logic               r_out_valid;
    logic               res_valid;
    logic               res_ready;

    logic                 pm_we, pm_re;
    logic [MA-1:0]        pm_waddr, pm_raddr;
    logic [WORD_BITS-1:0] pm_wdata, pm_rdata;
    logic                 sw_we, sw_re;
    logic [SA-1:0]        sw_waddr, sw_raddr;
    logic [WORD_BITS-1:0] sw_wdata, sw_rdata;
    logic                 sv_we, sv_re, sv_wdata, sv_rdata;
    logic [NP-1:0]        sv_waddr, sv_raddr;

    // Unpack the request transfer.
    assign req.req_type        = i_s_axis_tuser[0];
    assign req.virtual_address = i_s_axis_tdata[31:0];
    assign req.write_data      = signed'(i_s_axis_tdata[63:32]);

    // The output register frees the sequencer once it has been loaded.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    hptvm_ctrl #(
        .OFFSET_BITS (OFFSET_BITS),
        .LEVELS      (LEVELS),
        .VADDR_BITS  (VADDR_BITS),
        .FRAME_COUNT (FRAME_COUNT),
        .WORD_BITS   (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_pm_we     (pm_we),
        .o_pm_waddr  (pm_waddr),
        .o_pm_wdata  (pm_wdata),
        .o_pm_re     (pm_re),
        .o_pm_raddr  (pm_raddr),
        .i_pm_rdata  (pm_rdata),
        .o_sw_we     (sw_we),
        .o_sw_waddr  (sw_waddr),
        .o_sw_wdata  (sw_wdata),
        .o_sw_re     (sw_re),
        .o_sw_raddr  (sw_raddr),
        .i_sw_rdata  (sw_rdata),
        .o_sv_we     (sv_we),
        .o_sv_waddr  (sv_waddr),
        .o_sv_wdata  (sv_wdata),
        .o_sv_re     (sv_re),
        .o_sv_raddr  (sv_raddr),
        .i_sv_rdata  (sv_rdata)
    );

    // Physical memory: frame-organized, frame zero holds the root table.
    hptvm_ram #(
        .WIDTH (WORD_BITS),
        .AW    (MA),
        .DEPTH (longint'(FRAME_COUNT) << OFFSET_BITS)
    ) u_phys (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_re    (pm_re),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    // Swap store: one page of words per virtual page, read only once saved.
    hptvm_ram #(
        .WIDTH (WORD_BITS),
        .AW    (SA)
    ) u_swap (
        .i_clk   (i_clk),
        .i_we    (sw_we),
        .i_waddr (sw_waddr),
        .i_wdata (sw_wdata),
        .i_re    (sw_re),
        .i_raddr (sw_raddr),
        .o_rdata (sw_rdata)
    );

    // Swap flags: one bit per virtual page, zeroed by the clearing pass.
    hptvm_ram #(
        .WIDTH (1),
        .AW    (NP)
    ) u_swap_flag (
        .i_clk   (i_clk),
        .i_we    (sv_we),
        .i_waddr (sv_waddr),
        .i_wdata (sv_wdata),
        .i_re    (sv_re),
        .i_raddr (sv_raddr),
        .o_rdata (sv_rdata)
    );

    // Output register: load on a sequencer transfer, drop on a downstream one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out.read_data;
    assign o_m_axis_tuser[0] = r_out.success;

endmodule
`default_nettype wire

/* sv/hptvm_checker.sv */
// Port-level assertions for the page-table walker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "hierarchical_page_table_vm_macros.svh"
module hptvm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic [0:0]  o_m_axis_tuser
);

    // Reset blocks requests and clears the result valid.
    `HPTVM_ASSERT_RST(a_rst_no_ready, i_clk, !i_rst_n, !o_s_axis_tready)
    `HPTVM_ASSERT_RST(a_rst_no_valid, i_clk, !i_rst_n, !o_m_axis_tvalid)
    // A failed request carries a zero word.
    `HPTVM_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == 32'd0)
    `HPTVM_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

endmodule

bind hierarchical_page_table_vm hptvm_checker u_checker (.*);
`default_nettype wire
